@@ rtl/rtdp_pkg.sv @@
// ============================================================================
// rtdp_pkg: shared types and constants for the RGB to device pixel converter
// Holds field widths, configuration register indexes and reset values, and
// the control structures passed between the config block and the datapath.
// ============================================================================
package rtdp_pkg;

    // Field widths fixed by the interface
    localparam int PIX_W     = 32;
    localparam int CHAN_W    = 8;
    localparam int LVL_W     = 3;
    localparam int IDX_W     = 8;
    localparam int CFG_IDX_W = 3;
    // Cube index: ((6 * 7 + 6) * 7 + 6) = 342 at most
    localparam int CI_W      = 9;
    // Rank counter, holds up to eight placed channel bits
    localparam int RANK_W    = 4;
    localparam int BITSEL_W  = 3;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE         = 3'd0,
        CFG_RED_LEVELS   = 3'd1,
        CFG_GREEN_LEVELS = 3'd2,
        CFG_BLUE_LEVELS  = 3'd3,
        CFG_RED_MASK     = 3'd4,
        CFG_GREEN_MASK   = 3'd5,
        CFG_BLUE_MASK    = 3'd6
    } cfg_idx_t;

    // Request types
    localparam logic REQ_CONVERT = 1'b0;
    localparam logic REQ_LOAD    = 1'b1;

    // Reset values
    localparam logic             RST_MODE         = 1'b1;
    localparam logic [LVL_W-1:0] RST_RED_LEVELS   = 3'd6;
    localparam logic [LVL_W-1:0] RST_GREEN_LEVELS = 3'd6;
    localparam logic [LVL_W-1:0] RST_BLUE_LEVELS  = 3'd5;
    localparam logic [PIX_W-1:0] RST_RED_MASK     = 32'h00FF_0000;
    localparam logic [PIX_W-1:0] RST_GREEN_MASK   = 32'h0000_FF00;
    localparam logic [PIX_W-1:0] RST_BLUE_MASK    = 32'h0000_00FF;

    // Per pixel bit: does this bit take a channel bit, and which one
    typedef struct packed {
        logic                hit;
        logic [BITSEL_W-1:0] bit_idx;
    } sel_t;

    // Config state seen by the datapath
    typedef struct packed {
        logic             tc_mode;
        logic [LVL_W-1:0] red_levels;
        logic [LVL_W-1:0] green_levels;
        logic [LVL_W-1:0] blue_levels;
        logic             masks_ok;
        logic             busy;
    } cfg_t;

endpackage

@@ rtl/rtdp_table.sv @@
// ============================================================================
// rtdp_table: cube pixel table
// Single write port, single read port with registered read data.
// ============================================================================
module rtdp_table #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [AW-1:0]              waddr,
    input  logic [rtdp_pkg::PIX_W-1:0] wdata,
    input  logic                       re,
    input  logic [AW-1:0]              raddr,
    output logic [rtdp_pkg::PIX_W-1:0] rdata
);

    logic [rtdp_pkg::PIX_W-1:0] mem [DEPTH];
    logic [rtdp_pkg::PIX_W-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, data held while not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/rtdp_cfg.sv @@
// ============================================================================
// rtdp_cfg: configuration registers and field-mask rank sweep
// Holds the register file. After reset and after every write it walks the
// pixel bits from the top down, one bit per cycle, and records for each mask
// bit which channel bit it receives. Busy is high for the whole walk.
// ============================================================================
module rtdp_cfg #(
    parameter int SCAN_BITS    = 32,
    parameter int CHANNEL_BITS = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    input  logic [rtdp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rtdp_pkg::PIX_W-1:0]     cfg_data,
    output rtdp_pkg::cfg_t                 cfg_o,
    output rtdp_pkg::sel_t                 red_sel   [SCAN_BITS],
    output rtdp_pkg::sel_t                 green_sel [SCAN_BITS],
    output rtdp_pkg::sel_t                 blue_sel  [SCAN_BITS]
);

    localparam int POS_W = $clog2(SCAN_BITS);
    localparam logic [POS_W-1:0] POS_TOP = POS_W'(SCAN_BITS - 1);
    localparam logic [rtdp_pkg::RANK_W-1:0] CH_CNT = rtdp_pkg::RANK_W'(CHANNEL_BITS);

    logic                            mode_reg;
    logic [rtdp_pkg::LVL_W-1:0]      red_lvl_reg;
    logic [rtdp_pkg::LVL_W-1:0]      green_lvl_reg;
    logic [rtdp_pkg::LVL_W-1:0]      blue_lvl_reg;
    logic [rtdp_pkg::PIX_W-1:0]      red_field_reg;
    logic [rtdp_pkg::PIX_W-1:0]      green_field_reg;
    logic [rtdp_pkg::PIX_W-1:0]      blue_field_reg;
    logic                            masks_ok_reg;
    logic                            busy_reg;
    logic [POS_W-1:0]                pos_reg;
    logic [rtdp_pkg::RANK_W-1:0]     red_rank_reg;
    logic [rtdp_pkg::RANK_W-1:0]     green_rank_reg;
    logic [rtdp_pkg::RANK_W-1:0]     blue_rank_reg;
    rtdp_pkg::sel_t                  red_sel_reg   [SCAN_BITS];
    rtdp_pkg::sel_t                  green_sel_reg [SCAN_BITS];
    rtdp_pkg::sel_t                  blue_sel_reg  [SCAN_BITS];

    logic [SCAN_BITS-1:0]            red_scan;
    logic [SCAN_BITS-1:0]            green_scan;
    logic [SCAN_BITS-1:0]            blue_scan;
    rtdp_pkg::sel_t                  red_sel_next;
    rtdp_pkg::sel_t                  green_sel_next;
    rtdp_pkg::sel_t                  blue_sel_next;
    logic                            masks_ok_next;

    // Selection for one mask bit given the count of set bits above it
    function automatic rtdp_pkg::sel_t sel_calc(
        input logic                        bit_set,
        input logic [rtdp_pkg::RANK_W-1:0] rank
    );
        rtdp_pkg::sel_t s;
        s.hit     = bit_set && (rank < CH_CNT);
        s.bit_idx = rtdp_pkg::BITSEL_W'(CH_CNT - rtdp_pkg::RANK_W'(1) - rank);
        return s;
    endfunction

    assign red_scan   = red_field_reg[SCAN_BITS-1:0];
    assign green_scan = green_field_reg[SCAN_BITS-1:0];
    assign blue_scan  = blue_field_reg[SCAN_BITS-1:0];

    assign red_sel_next   = sel_calc(red_scan[pos_reg], red_rank_reg);
    assign green_sel_next = sel_calc(green_scan[pos_reg], green_rank_reg);
    assign blue_sel_next  = sel_calc(blue_scan[pos_reg], blue_rank_reg);

    // Zero masks or a bit shared by all three make the format invalid
    assign masks_ok_next = (red_field_reg != '0) && (green_field_reg != '0) &&
                           (blue_field_reg != '0) &&
                           ((red_field_reg & green_field_reg & blue_field_reg) == '0);

    // Register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= rtdp_pkg::RST_MODE;
            red_lvl_reg     <= rtdp_pkg::RST_RED_LEVELS;
            green_lvl_reg   <= rtdp_pkg::RST_GREEN_LEVELS;
            blue_lvl_reg    <= rtdp_pkg::RST_BLUE_LEVELS;
            red_field_reg   <= rtdp_pkg::RST_RED_MASK;
            green_field_reg <= rtdp_pkg::RST_GREEN_MASK;
            blue_field_reg  <= rtdp_pkg::RST_BLUE_MASK;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                rtdp_pkg::CFG_MODE:         mode_reg        <= cfg_data[0];
                rtdp_pkg::CFG_RED_LEVELS:   red_lvl_reg     <= cfg_data[rtdp_pkg::LVL_W-1:0];
                rtdp_pkg::CFG_GREEN_LEVELS: green_lvl_reg   <= cfg_data[rtdp_pkg::LVL_W-1:0];
                rtdp_pkg::CFG_BLUE_LEVELS:  blue_lvl_reg    <= cfg_data[rtdp_pkg::LVL_W-1:0];
                rtdp_pkg::CFG_RED_MASK:     red_field_reg   <= cfg_data;
                rtdp_pkg::CFG_GREEN_MASK:   green_field_reg <= cfg_data;
                rtdp_pkg::CFG_BLUE_MASK:    blue_field_reg  <= cfg_data;
                default:                    ;
            endcase
        end
    end

    // Sweep control: restart on any write, walk top bit down to bit 0
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b1;
            pos_reg        <= POS_TOP;
            red_rank_reg   <= '0;
            green_rank_reg <= '0;
            blue_rank_reg  <= '0;
            masks_ok_reg   <= 1'b0;
        end
        else
        begin
            masks_ok_reg <= masks_ok_next;
            if (cfg_valid)
            begin
                busy_reg       <= 1'b1;
                pos_reg        <= POS_TOP;
                red_rank_reg   <= '0;
                green_rank_reg <= '0;
                blue_rank_reg  <= '0;
            end
            else if (busy_reg)
            begin
                red_rank_reg   <= red_rank_reg + rtdp_pkg::RANK_W'(red_sel_next.hit);
                green_rank_reg <= green_rank_reg + rtdp_pkg::RANK_W'(green_sel_next.hit);
                blue_rank_reg  <= blue_rank_reg + rtdp_pkg::RANK_W'(blue_sel_next.hit);
                if (pos_reg == '0)
                begin
                    busy_reg <= 1'b0;
                end
                else
                begin
                    pos_reg <= pos_reg - POS_W'(1);
                end
            end
        end
    end

    // Selection table, one entry per cycle of the sweep
    always_ff @(posedge clk)
    begin
        if (busy_reg && !cfg_valid)
        begin
            red_sel_reg[pos_reg]   <= red_sel_next;
            green_sel_reg[pos_reg] <= green_sel_next;
            blue_sel_reg[pos_reg]  <= blue_sel_next;
        end
    end

    assign red_sel   = red_sel_reg;
    assign green_sel = green_sel_reg;
    assign blue_sel  = blue_sel_reg;

    always_comb
    begin
        cfg_o.tc_mode      = mode_reg;
        cfg_o.red_levels   = red_lvl_reg;
        cfg_o.green_levels = green_lvl_reg;
        cfg_o.blue_levels  = blue_lvl_reg;
        cfg_o.masks_ok     = masks_ok_reg;
        cfg_o.busy         = busy_reg;
    end

endmodule

@@ rtl/rgb_to_device_pixel.sv @@
// ============================================================================
// rgb_to_device_pixel: RGB888 to device pixel word converter
// True-color mode deals channel bits into field masks; cube mode scales the
// channels to cube levels and reads a loadable pixel table.
// ============================================================================
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------------
//  in      | input     | in_valid / in_ready  | req_type red green blue
//          |           |                      | entry_index entry_pixel
//  out     | output    | out_valid/out_ready  | pixel format_ok
//  cfg     | input     | cfg_valid/cfg_ready  | cfg_index cfg_data
//
//  One request per cycle while in_ready is high; a convert request passes
//  through stage 1 (loaded at the accepting edge), stages 2 to 4 and the
//  output register before out_valid rises. Load requests write the table in
//  stage 3 and produce no result.
//  After reset and after every config write, in_ready stays low while the
//  mask rank table is rebuilt over the low min(PIXEL_BITS, 32) pixel bits,
//  one pixel bit per cycle. cfg_ready is always high.
//  Each stage holds when the stage after it is full and stalled; empty
//  stages still take new data, so bubbles close up under a stall.
//
module rgb_to_device_pixel #(
    parameter int TABLE_DEPTH  = 256,
    parameter int PIXEL_BITS   = 32,
    parameter int CHANNEL_BITS = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           req_type,
    input  logic [rtdp_pkg::CHAN_W-1:0]    red,
    input  logic [rtdp_pkg::CHAN_W-1:0]    green,
    input  logic [rtdp_pkg::CHAN_W-1:0]    blue,
    input  logic [rtdp_pkg::IDX_W-1:0]     entry_index,
    input  logic [rtdp_pkg::PIX_W-1:0]     entry_pixel,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [rtdp_pkg::PIX_W-1:0]     pixel,
    output logic                           format_ok,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [rtdp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rtdp_pkg::PIX_W-1:0]     cfg_data
);

    localparam int SCAN_BITS = (PIXEL_BITS < 32) ? PIXEL_BITS : 32;
    localparam int AW        = $clog2(TABLE_DEPTH);
    localparam logic [rtdp_pkg::PIX_W-1:0] OUT_MASK =
        rtdp_pkg::PIX_W'((64'd1 << SCAN_BITS) - 64'd1);
    localparam logic [rtdp_pkg::CI_W-1:0] DEPTH_LIM = rtdp_pkg::CI_W'(TABLE_DEPTH);
    localparam int PROD_W = rtdp_pkg::CHAN_W + rtdp_pkg::LVL_W;
    localparam int T_W    = 6;

    rtdp_pkg::cfg_t                 cfg;
    rtdp_pkg::sel_t                 red_sel   [SCAN_BITS];
    rtdp_pkg::sel_t                 green_sel [SCAN_BITS];
    rtdp_pkg::sel_t                 blue_sel  [SCAN_BITS];

    // Stage enables
    logic en1, en2, en3, en4, en_out;

    // Stage 1: levels and true-color placement
    logic                           v1_reg;
    logic                           load1_reg;
    logic [rtdp_pkg::LVL_W-1:0]     rl1_reg, gl1_reg, bl1_reg;
    logic [rtdp_pkg::IDX_W-1:0]     idx1_reg;
    logic [rtdp_pkg::PIX_W-1:0]     epix1_reg;
    logic [SCAN_BITS-1:0]           tc1_reg;
    logic [PROD_W-1:0]              rprod, gprod, bprod;
    logic [SCAN_BITS-1:0]           tc1_next;

    // Stage 2: red * green levels + green level
    logic                           v2_reg;
    logic                           load2_reg;
    logic [T_W-1:0]                 t2_reg;
    logic [rtdp_pkg::LVL_W-1:0]     bl2_reg;
    logic [rtdp_pkg::IDX_W-1:0]     idx2_reg;
    logic [rtdp_pkg::PIX_W-1:0]     epix2_reg;
    logic [SCAN_BITS-1:0]           tc2_reg;
    logic [T_W-1:0]                 t2_next;

    // Stage 3: cube index, table access on the way out
    logic                           v3_reg;
    logic                           load3_reg;
    logic [rtdp_pkg::CI_W-1:0]      ci3_reg;
    logic [rtdp_pkg::IDX_W-1:0]     idx3_reg;
    logic [rtdp_pkg::PIX_W-1:0]     epix3_reg;
    logic [SCAN_BITS-1:0]           tc3_reg;
    logic [rtdp_pkg::CI_W-1:0]      ci3_next;
    logic                           ci_in_range;
    logic                           load_in_range;
    logic                           tbl_we;
    logic                           tbl_re;

    // Stage 4: table data and result select
    logic                           v4_reg;
    logic                           inr4_reg;
    logic [SCAN_BITS-1:0]           tc4_reg;
    logic [rtdp_pkg::PIX_W-1:0]     tbl_rdata;
    logic [rtdp_pkg::PIX_W-1:0]     pixel_next;
    logic                           ok_next;

    // Output register
    logic                           out_valid_reg;
    logic [rtdp_pkg::PIX_W-1:0]     pixel_reg;
    logic                           ok_reg;

    rtdp_cfg #(
        .SCAN_BITS    (SCAN_BITS),
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_o     (cfg),
        .red_sel   (red_sel),
        .green_sel (green_sel),
        .blue_sel  (blue_sel)
    );

    assign cfg_ready = 1'b1;

    // Backpressure: a stage takes new data when empty or when it moves on
    assign en_out   = !out_valid_reg || out_ready;
    assign en4      = !v4_reg || en_out;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1 && !cfg.busy;

    // Stage 1 logic: channel to cube level, mask placement
    assign rprod = PROD_W'(red) * PROD_W'(cfg.red_levels);
    assign gprod = PROD_W'(green) * PROD_W'(cfg.green_levels);
    assign bprod = PROD_W'(blue) * PROD_W'(cfg.blue_levels);

    always_comb
    begin
        tc1_next = '0;
        for (int p = 0; p < SCAN_BITS; p++)
        begin
            tc1_next[p] = (red_sel[p].hit   && red[red_sel[p].bit_idx])     ||
                          (green_sel[p].hit && green[green_sel[p].bit_idx]) ||
                          (blue_sel[p].hit  && blue[blue_sel[p].bit_idx]);
        end
    end

    // Stage 2 and 3 logic: combined cube index
    assign t2_next  = T_W'(rl1_reg) * T_W'(cfg.green_levels) + T_W'(gl1_reg);
    assign ci3_next = rtdp_pkg::CI_W'(t2_reg) * rtdp_pkg::CI_W'(cfg.blue_levels) +
                      rtdp_pkg::CI_W'(bl2_reg);

    assign ci_in_range   = ci3_reg < DEPTH_LIM;
    assign load_in_range = {1'b0, idx3_reg} < DEPTH_LIM;
    assign tbl_we = en4 && v3_reg && load3_reg && load_in_range;
    assign tbl_re = en4 && v3_reg && !load3_reg && ci_in_range;

    rtdp_table #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (idx3_reg[AW-1:0]),
        .wdata (epix3_reg),
        .re    (tbl_re),
        .raddr (ci3_reg[AW-1:0]),
        .rdata (tbl_rdata)
    );

    // Stage 4 logic: pick result by mode
    always_comb
    begin
        if (cfg.tc_mode)
        begin
            pixel_next = cfg.masks_ok ? rtdp_pkg::PIX_W'(tc4_reg) : '0;
            ok_next    = cfg.masks_ok;
        end
        else
        begin
            pixel_next = inr4_reg ? (tbl_rdata & OUT_MASK) : '0;
            ok_next    = inr4_reg;
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= in_valid && in_ready;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
            if (en4)
            begin
                // loads end at the table
                v4_reg <= v3_reg && !load3_reg;
            end
            if (en_out)
            begin
                out_valid_reg <= v4_reg;
            end
        end
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            load1_reg <= (req_type == rtdp_pkg::REQ_LOAD);
            rl1_reg   <= rprod[PROD_W-1:rtdp_pkg::CHAN_W];
            gl1_reg   <= gprod[PROD_W-1:rtdp_pkg::CHAN_W];
            bl1_reg   <= bprod[PROD_W-1:rtdp_pkg::CHAN_W];
            idx1_reg  <= entry_index;
            epix1_reg <= entry_pixel;
            tc1_reg   <= tc1_next;
        end
        if (en2)
        begin
            load2_reg <= load1_reg;
            t2_reg    <= t2_next;
            bl2_reg   <= bl1_reg;
            idx2_reg  <= idx1_reg;
            epix2_reg <= epix1_reg;
            tc2_reg   <= tc1_reg;
        end
        if (en3)
        begin
            load3_reg <= load2_reg;
            ci3_reg   <= ci3_next;
            idx3_reg  <= idx2_reg;
            epix3_reg <= epix2_reg;
            tc3_reg   <= tc2_reg;
        end
        if (en4)
        begin
            inr4_reg <= ci_in_range;
            tc4_reg  <= tc3_reg;
        end
        if (en_out)
        begin
            pixel_reg <= pixel_next;
            ok_reg    <= ok_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign pixel     = pixel_reg;
    assign format_ok = ok_reg;

`ifndef SYNTH
    // No request may enter while the rank table is being rebuilt
    a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        cfg.busy |-> !in_ready)
        else $error("request accepted during rank sweep");

    // A load leaving stage 3 never creates a result
    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (en4 && v3_reg && load3_reg) |=> !v4_reg)
        else $error("load request produced a result");

    // An invalid result always carries a zero pixel
    a_bad_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !format_ok) |-> (pixel == '0))
        else $error("invalid result with nonzero pixel");

    // Table write and read never happen in the same cycle
    a_one_table_access: assert property (@(posedge clk) disable iff (!rst_n)
        !(tbl_we && tbl_re))
        else $error("table written and read together");
`endif

endmodule
